// ===== hdl/debounced_door_and_service_inputs_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the door and service input debouncer
// Shared forms for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_DOOR_AND_SERVICE_INPUTS_DEFINES_SVH
`define DEBOUNCED_DOOR_AND_SERVICE_INPUTS_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DDSI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define DDSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ddsi_pkg.sv =====
// ----------------------------------------------------------------------------
// ddsi_pkg
// Types, codes and the per-input debounce step for the door and service
// input debouncer.
// ----------------------------------------------------------------------------
package ddsi_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam logic [TimeW-1:0] DefaultInterval = 32'd50;

  // Input slots
  localparam int unsigned InSvc  = 0;
  localparam int unsigned InSide = 1;
  localparam int unsigned InRear = 2;
  localparam int unsigned InCount = 3;

  typedef enum logic {
    REQ_INIT = 1'b0,
    REQ_POLL = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    EV_INIT_OK     = 3'd0,
    EV_INIT_FAIL   = 3'd1,
    EV_SVC_ON      = 3'd2,
    EV_SVC_OFF     = 3'd3,
    EV_SIDE_OPENED = 3'd4,
    EV_SIDE_CLOSED = 3'd5,
    EV_REAR_OPENED = 3'd6,
    EV_REAR_CLOSED = 3'd7
  } event_t;

  typedef struct packed {
    event_t code;
    logic   last;
  } entry_t;

  typedef struct packed {
    logic             cand;
    logic             stable;
    logic [TimeW-1:0] since;
    logic             changed;
  } deb_t;

  // One debounce step: track the candidate, promote it once held long enough
  function automatic deb_t debounce_step(
    input logic             act,
    input logic             cand,
    input logic             stable,
    input logic [TimeW-1:0] since,
    input logic [TimeW-1:0] now,
    input logic [TimeW-1:0] interval
  );
    deb_t             r;
    logic [TimeW-1:0] elapsed;
    r.cand    = act;
    r.since   = (act != cand) ? now : since;
    elapsed   = now - r.since;
    r.changed = (act != stable) && (elapsed >= interval);
    r.stable  = r.changed ? act : stable;
    return r;
  endfunction

endpackage

// ===== hdl/debounced_door_and_service_inputs.sv =====
// ----------------------------------------------------------------------------
// debounced_door_and_service_inputs
// Debounces a service switch and two door contacts from timestamped samples
// and reports init status, service mode changes and door events.
// ----------------------------------------------------------------------------
// A sample is taken every cycle unless sample_stall holds it. It is
// registered, then debounced in one pass against the stored stable and
// candidate states (one 32-bit subtract and compare per input), and its
// events are written into a four-entry event queue that feeds the event
// port. Each sample gives zero, one or two events; the event port delivers
// one event per cycle while event_stall is low, and the queue stalls the
// sample port when fewer than two entries are free.
// The debounce interval is written through the configuration port and
// resets to 50 ms.
`include "debounced_door_and_service_inputs_defines.svh"

module debounced_door_and_service_inputs
  import ddsi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TimeW-1:0] debounce_interval,
  // sample channel
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic             req_type,
  input  logic [TimeW-1:0] now_ms,
  input  logic             expander_ok,
  input  logic             service_level,
  input  logic             service_ok,
  input  logic             side_level,
  input  logic             side_ok,
  input  logic             rear_level,
  input  logic             rear_ok,
  // event channel
  output logic             event_valid,
  input  logic             event_stall,
  output logic [2:0]       event_code,
  output logic             last_event
);

  // Configuration and debounce state
  logic [TimeW-1:0] interval;
  logic             ready_flag;
  logic             service_mode;
  logic [InCount-1:0] stable_active;
  logic [InCount-1:0] candidate_active;
  logic [TimeW-1:0]   held_since [InCount];

  // Sample register
  logic             s1_valid;
  req_t             s1_req;
  logic [TimeW-1:0] s1_now;
  logic             s1_exp_ok;
  logic [InCount-1:0] s1_act;
  logic [InCount-1:0] s1_ok;

  // Event queue
  entry_t           queue [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  // Next values
  logic               ready_flag_next;
  logic               service_mode_next;
  logic [InCount-1:0] stable_next;
  logic [InCount-1:0] cand_next;
  logic [TimeW-1:0]   since_next [InCount];
  logic [1:0]         push_n;
  entry_t             ent0;
  entry_t             ent1;

  logic advance;
  logic load;
  logic pop;
  logic seed0, seed1, seed2;
  logic svc_new;
  logic side_emit, rear_emit;
  deb_t d_svc, d_side, d_rear;

  assign cfg_ready    = 1'b1;
  assign advance      = s1_valid && (count <= QCntW'(QDepth - 2));
  assign sample_stall = s1_valid && !advance;
  assign load         = sample_valid && !sample_stall;
  assign pop          = event_valid && !event_stall;

  assign event_valid  = (count != '0);
  assign event_code   = queue[rd_ptr].code;
  assign last_event   = queue[rd_ptr].last;

  // Debounce each input from the registered sample
  assign d_svc  = debounce_step(s1_act[InSvc], candidate_active[InSvc], stable_active[InSvc],
                                held_since[InSvc], s1_now, interval);
  assign d_side = debounce_step(s1_act[InSide], candidate_active[InSide],
                                stable_active[InSide], held_since[InSide], s1_now,
                                interval);
  assign d_rear = debounce_step(s1_act[InRear], candidate_active[InRear],
                                stable_active[InRear], held_since[InRear], s1_now,
                                interval);

  // Seed chain for init: stop at the first failed read
  assign seed0 = s1_exp_ok && s1_ok[InSvc];
  assign seed1 = seed0 && s1_ok[InSide];
  assign seed2 = seed1 && s1_ok[InRear];

  // Work out the state update and the events of the registered sample
  always_comb begin
    ready_flag_next   = ready_flag;
    service_mode_next = service_mode;
    stable_next       = stable_active;
    cand_next         = candidate_active;
    for (int k = 0; k < InCount; k++) begin
      since_next[k] = held_since[k];
    end
    push_n    = 2'd0;
    ent0      = '{code: EV_INIT_OK, last: 1'b1};
    ent1      = '{code: EV_INIT_OK, last: 1'b1};
    svc_new   = service_mode;
    side_emit = 1'b0;
    rear_emit = 1'b0;

    if (s1_req == REQ_INIT) begin
      if (seed0) begin
        stable_next[InSvc] = s1_act[InSvc];
        cand_next[InSvc]   = s1_act[InSvc];
        since_next[InSvc]  = s1_now;
      end
      if (seed1) begin
        stable_next[InSide] = s1_act[InSide];
        cand_next[InSide]   = s1_act[InSide];
        since_next[InSide]  = s1_now;
      end
      if (seed2) begin
        stable_next[InRear] = s1_act[InRear];
        cand_next[InRear]   = s1_act[InRear];
        since_next[InRear]  = s1_now;
        service_mode_next   = s1_act[InSvc];
        ready_flag_next     = 1'b1;
      end
      push_n    = 2'd1;
      ent0.code = seed2 ? EV_INIT_OK : EV_INIT_FAIL;
      ent0.last = 1'b1;
    end else if (ready_flag && s1_ok[InSvc]) begin
      // service switch
      stable_next[InSvc] = d_svc.stable;
      cand_next[InSvc]   = d_svc.cand;
      since_next[InSvc]  = d_svc.since;
      svc_new            = d_svc.changed ? s1_act[InSvc] : service_mode;
      service_mode_next  = svc_new;
      // doors: follow the level, report only outside service mode and when the service switch did not change
      if (s1_ok[InSide]) begin
        stable_next[InSide] = d_side.stable;
        cand_next[InSide]   = d_side.cand;
        since_next[InSide]  = d_side.since;
        side_emit           = d_side.changed && !svc_new && !d_svc.changed;
      end
      if (s1_ok[InRear]) begin
        stable_next[InRear] = d_rear.stable;
        cand_next[InRear]   = d_rear.cand;
        since_next[InRear]  = d_rear.since;
        rear_emit           = d_rear.changed && !svc_new && !d_svc.changed;
      end
      // pack events in order: service, side, rear
      push_n = 2'({1'b0, d_svc.changed} + {1'b0, side_emit} + {1'b0, rear_emit});
      priority if (d_svc.changed) begin
        ent0.code = s1_act[InSvc] ? EV_SVC_ON : EV_SVC_OFF;
      end else if (side_emit) begin
        ent0.code = d_side.stable ? EV_SIDE_OPENED : EV_SIDE_CLOSED;
      end else begin
        ent0.code = d_rear.stable ? EV_REAR_OPENED : EV_REAR_CLOSED;
      end
      ent0.last = (push_n == 2'd1);
      ent1.code = d_rear.stable ? EV_REAR_OPENED : EV_REAR_CLOSED;
      ent1.last = 1'b1;
    end
  end

  // Hold configuration and debounce state
  always_ff @(posedge clk) begin
    if (rst) begin
      interval         <= DefaultInterval;
      ready_flag       <= 1'b0;
      service_mode     <= 1'b0;
      stable_active    <= '0;
      candidate_active <= '0;
      for (int k = 0; k < InCount; k++) begin
        held_since[k] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        interval <= debounce_interval;
      end
      if (advance) begin
        ready_flag       <= ready_flag_next;
        service_mode     <= service_mode_next;
        stable_active    <= stable_next;
        candidate_active <= cand_next;
        for (int k = 0; k < InCount; k++) begin
          held_since[k] <= since_next[k];
        end
      end
    end
  end

  // Sample register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Sample register: payload, decoded to active levels
  always_ff @(posedge clk) begin
    if (load) begin
      s1_req          <= req_t'(req_type);
      s1_now          <= now_ms;
      s1_exp_ok       <= expander_ok;
      s1_act[InSvc]   <= !service_level;
      s1_act[InSide]  <= !side_level;
      s1_act[InRear]  <= !rear_level;
      s1_ok[InSvc]    <= service_ok;
      s1_ok[InSide]   <= side_ok;
      s1_ok[InRear]   <= rear_ok;
    end
  end

  // Event queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + QPtrW'(push_n);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      count <= count + QCntW'(advance ? push_n : 2'd0) - QCntW'(pop);
    end
  end

  // Event queue storage
  always_ff @(posedge clk) begin
    if (advance && (push_n != 2'd0)) begin
      queue[wr_ptr] <= ent0;
    end
    if (advance && (push_n == 2'd2)) begin
      queue[wr_ptr + QPtrW'(1)] <= ent1;
    end
  end

  `DDSI_ASSERT_NOW(a_queue_room, clk, rst, advance, count <= QCntW'(QDepth - 2),
    "event queue advanced without room for two events")
  `DDSI_ASSERT_NOW(a_init_one_event, clk, rst, advance && (s1_req == REQ_INIT),
    push_n == 2'd1 && ent0.last, "init sample did not give exactly one event")
  `DDSI_ASSERT_NOW(a_poll_not_ready, clk, rst,
    advance && (s1_req == REQ_POLL) && !ready_flag, push_n == 2'd0,
    "poll before init gave an event")
  `DDSI_ASSERT_NEXT(a_init_sets_ready, clk, rst,
    advance && (s1_req == REQ_INIT) && seed2, ready_flag,
    "successful init did not set the ready flag")

endmodule
